@@ sv/wsi_pkg.sv @@
// ----------------------------------------------------------------------------
// wsi_pkg
// Shared types and constants of the wide-string to 64-bit integer parser.
// ----------------------------------------------------------------------------
package wsi_pkg;

    localparam int NUM_BLOCKS = 18;
    localparam int NUM_SPACES = 26;

    // zero code of each Unicode decimal digit block
    localparam logic [15:0] DIGIT_BLOCKS [NUM_BLOCKS] = '{
        16'h0030, 16'h0660, 16'h06F0, 16'h0966, 16'h09E6, 16'h0A66,
        16'h0AE6, 16'h0B66, 16'h0C66, 16'h0CE6, 16'h0D66, 16'h0E50,
        16'h0ED0, 16'h0F20, 16'h1040, 16'h17E0, 16'h1810, 16'hFF10
    };

    localparam logic [15:0] SPACE_CODES [NUM_SPACES] = '{
        16'h0009, 16'h000A, 16'h000B, 16'h000C, 16'h000D, 16'h0020,
        16'h0085, 16'h00A0, 16'h1680, 16'h180E, 16'h2000, 16'h2001,
        16'h2002, 16'h2003, 16'h2004, 16'h2005, 16'h2006, 16'h2007,
        16'h2008, 16'h2009, 16'h200A, 16'h2028, 16'h2029, 16'h202F,
        16'h205F, 16'h3000
    };

    localparam logic [15:0] CH_ZERO    = 16'h0030;
    localparam logic [15:0] CH_PLUS    = 16'h002B;
    localparam logic [15:0] CH_MINUS   = 16'h002D;
    localparam logic [15:0] CH_LOWER_X = 16'h0078;
    localparam logic [15:0] CH_UPPER_X = 16'h0058;
    localparam logic [15:0] CH_LOWER_A = 16'h0061;
    localparam logic [15:0] CH_LOWER_Z = 16'h007A;
    localparam logic [15:0] CH_UPPER_A = 16'h0041;
    localparam logic [15:0] CH_UPPER_Z = 16'h005A;

    localparam logic [6:0] DIGIT_NONE = 7'd99;

    localparam logic [5:0] BASE_AUTO = 6'd0;
    localparam logic [5:0] BASE_OCT  = 6'd8;
    localparam logic [5:0] BASE_DEC  = 6'd10;
    localparam logic [5:0] BASE_HEX  = 6'd16;

    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    // register indexes (word address)
    localparam logic [1:0] REG_NUMBER_BASE    = 2'd0;
    localparam logic [1:0] REG_SIGNED_MODE    = 2'd1;
    localparam logic [1:0] REG_ANY_BLOCK_ZERO = 2'd2;

    typedef struct packed {
        logic [5:0] number_base;
        logic       signed_mode;
        logic       any_block_zero;
    } t_cfg;

    typedef struct packed {
        logic       is_space;
        logic       prefix_zero;
        logic [6:0] digit;
    } t_char_class;

    typedef struct packed {
        logic [63:0] value;
        logic [15:0] end_offset;
        logic        range_error;
        logic        no_digits;
    } t_result;

endpackage

@@ sv/wsi_stream_if.sv @@
// ----------------------------------------------------------------------------
// wsi_char_if / wsi_result_if
// Valid/ready channels for code units in and parse results out.
// ----------------------------------------------------------------------------
interface wsi_char_if;
    logic        valid;
    logic        ready;
    logic [15:0] char_code;
    logic        string_start;

    modport source (output valid, output char_code, output string_start, input ready);
    modport sink   (input valid, input char_code, input string_start, output ready);
endinterface

interface wsi_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [15:0] end_offset;
    logic        range_error;
    logic        no_digits;

    modport source (output valid, output value, output end_offset, output range_error,
                    output no_digits, input ready);
    modport sink   (input valid, input value, input end_offset, input range_error,
                    input no_digits, output ready);
endinterface

@@ sv/wsi_apb_regs.sv @@
// ----------------------------------------------------------------------------
// wsi_apb_regs
// APB configuration registers: number base, signed mode, any-block zero.
// ----------------------------------------------------------------------------
module wsi_apb_regs import wsi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.number_base    <= BASE_AUTO;
            r_cfg.signed_mode    <= 1'b1;
            r_cfg.any_block_zero <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_NUMBER_BASE:    r_cfg.number_base    <= pwdata[5:0];
                REG_SIGNED_MODE:    r_cfg.signed_mode    <= pwdata[0];
                REG_ANY_BLOCK_ZERO: r_cfg.any_block_zero <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NUMBER_BASE:    prdata = {26'd0, r_cfg.number_base};
            REG_SIGNED_MODE:    prdata = {31'd0, r_cfg.signed_mode};
            REG_ANY_BLOCK_ZERO: prdata = {31'd0, r_cfg.any_block_zero};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

@@ sv/wsi_char_class.sv @@
// ----------------------------------------------------------------------------
// wsi_char_class
// Classifies one UTF-16 code unit: whitespace, digit value, prefix zero.
// ----------------------------------------------------------------------------
module wsi_char_class import wsi_pkg::*; (
    input  logic [15:0]  i_char_code,
    input  logic         i_any_block_zero,
    output t_char_class  o_class
);

    logic [15:0] diff [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] blk_hit;
    logic [NUM_BLOCKS-1:0] blk_zero;
    logic [NUM_SPACES-1:0] sp_hit;
    logic [3:0]  blk_digit;

    always_comb begin
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            diff[i]     = i_char_code - DIGIT_BLOCKS[i];
            blk_hit[i]  = (diff[i] <= 16'd9);
            blk_zero[i] = (i_char_code == DIGIT_BLOCKS[i]);
        end
        for (int i = 0; i < NUM_SPACES; i++) begin
            sp_hit[i] = (i_char_code == SPACE_CODES[i]);
        end
    end

    // blocks do not overlap, so at most one hits
    always_comb begin
        blk_digit = 4'd0;
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            if (blk_hit[i]) blk_digit = diff[i][3:0];
        end
    end

    always_comb begin
        o_class.is_space    = |sp_hit;
        o_class.prefix_zero = i_any_block_zero ? (|blk_zero) : (i_char_code == CH_ZERO);
        priority if (|blk_hit) begin
            o_class.digit = {3'd0, blk_digit};
        end else if (i_char_code >= CH_LOWER_A && i_char_code <= CH_LOWER_Z) begin
            o_class.digit = 7'(i_char_code - CH_LOWER_A) + 7'd10;
        end else if (i_char_code >= CH_UPPER_A && i_char_code <= CH_UPPER_Z) begin
            o_class.digit = 7'(i_char_code - CH_UPPER_A) + 7'd10;
        end else begin
            o_class.digit = DIGIT_NONE;
        end
    end

endmodule

@@ sv/wsi_parse_core.sv @@
// ----------------------------------------------------------------------------
// wsi_parse_core
// Input register, per-unit parse step with multiply-add limit test, and
// result register.
// ----------------------------------------------------------------------------
module wsi_parse_core import wsi_pkg::*; #(
    parameter int OFFSET_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_char_code,
    input  logic        i_string_start,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output t_result     o_res
);

    localparam int POS_W = (OFFSET_WIDTH < 16) ? OFFSET_WIDTH : 16;

    typedef enum logic [2:0] {
        PH_SPACE, PH_SIGNED, PH_ZERO, PH_NONE, PH_SOME
    } t_phase;

    logic             r_in_valid;
    logic [15:0]      r_in_code;
    logic             r_in_start;

    t_phase           r_phase, n_phase;
    logic             r_neg, n_neg;
    logic [5:0]       r_base, n_base;
    logic [63:0]      r_acc, n_acc;
    logic             r_ovf, n_ovf;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_fin, n_fin;

    logic             r_res_valid;
    t_result          r_res, n_res;

    t_char_class      cls;
    logic             fire;
    logic             emit;
    logic             stop;
    logic             first;
    logic [POS_W-1:0] here;
    logic             dig_ok;
    logic [69:0]      prod;
    logic [63:0]      lim;

    wsi_char_class u_class (
        .i_char_code      (r_in_code),
        .i_any_block_zero (i_cfg.any_block_zero),
        .o_class          (cls)
    );

    // only a request that produces a result waits for the result register
    assign fire        = r_in_valid && (!emit || !r_res_valid || i_res_ready);
    assign o_in_ready  = !r_in_valid || fire;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_base  = r_base;
        n_acc   = r_acc;
        n_ovf   = r_ovf;
        n_pos   = r_pos;
        n_fin   = r_fin;
        emit    = 1'b0;
        stop    = 1'b0;
        first   = 1'b0;
        here    = r_pos;
        dig_ok  = 1'b0;
        prod    = '0;
        lim     = U64_MAX;
        n_res   = r_res;

        if (r_in_start) begin
            n_phase = PH_SPACE;
            n_neg   = 1'b0;
            n_base  = BASE_AUTO;
            n_acc   = '0;
            n_ovf   = 1'b0;
            n_pos   = '0;
            n_fin   = 1'b0;
        end

        if (!n_fin) begin
            here = n_pos;
            if (n_pos != '1) n_pos = n_pos + 1'b1;

            unique case (n_phase)
                PH_SPACE: begin
                    priority if (cls.is_space) begin
                        stop = 1'b1;
                    end else if (r_in_code == CH_MINUS) begin
                        n_neg   = 1'b1;
                        n_phase = PH_SIGNED;
                        stop    = 1'b1;
                    end else if (r_in_code == CH_PLUS) begin
                        n_phase = PH_SIGNED;
                        stop    = 1'b1;
                    end else begin
                        first = 1'b1;
                    end
                end
                PH_SIGNED: first = 1'b1;
                PH_ZERO: begin
                    if (r_in_code == CH_LOWER_X || r_in_code == CH_UPPER_X) begin
                        n_base  = BASE_HEX;
                        n_phase = PH_NONE;
                        stop    = 1'b1;
                    end else begin
                        // the pending zero counts as a digit
                        if (n_base == BASE_AUTO) n_base = BASE_OCT;
                        n_phase = PH_SOME;
                    end
                end
                PH_NONE, PH_SOME: ;
                default: ;
            endcase

            if (!stop && first) begin
                if ((i_cfg.number_base == BASE_AUTO || i_cfg.number_base == BASE_HEX)
                    && cls.prefix_zero) begin
                    n_base  = i_cfg.number_base;
                    n_phase = PH_ZERO;
                    stop    = 1'b1;
                end else begin
                    n_base  = (i_cfg.number_base == BASE_AUTO) ? BASE_DEC
                                                               : i_cfg.number_base;
                    n_phase = PH_NONE;
                end
            end

            if (!stop) begin
                // acc*base + d > lim is the same test as the cutoff/cutlim check
                dig_ok = (n_base != BASE_AUTO) && (cls.digit < {1'b0, n_base});
                lim    = i_cfg.signed_mode ? (n_neg ? S64_MIN : S64_MAX) : U64_MAX;
                prod   = n_acc * n_base + 70'(cls.digit[5:0]);
                if (dig_ok) begin
                    if (!n_ovf) begin
                        if (prod > 70'(lim)) n_ovf = 1'b1;
                        else                 n_acc = prod[63:0];
                    end
                    n_phase = PH_SOME;
                end else begin
                    n_fin = 1'b1;
                    emit  = 1'b1;
                    if (n_phase != PH_SOME) begin
                        n_res.value       = '0;
                        n_res.end_offset  = '0;
                        n_res.range_error = 1'b0;
                        n_res.no_digits   = 1'b1;
                    end else begin
                        if (n_ovf) begin
                            n_res.value = i_cfg.signed_mode ? (n_neg ? S64_MIN : S64_MAX)
                                                            : U64_MAX;
                        end else begin
                            n_res.value = n_neg ? (64'd0 - n_acc) : n_acc;
                        end
                        n_res.range_error = n_ovf;
                        n_res.end_offset  = 16'(here);
                        n_res.no_digits   = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= PH_SPACE;
            r_neg       <= 1'b0;
            r_base      <= BASE_AUTO;
            r_acc       <= '0;
            r_ovf       <= 1'b0;
            r_pos       <= '0;
            r_fin       <= 1'b1;
            r_res_valid <= 1'b0;
        end else begin
            if (o_in_ready) r_in_valid <= i_in_valid;
            if (fire) begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_base  <= n_base;
                r_acc   <= n_acc;
                r_ovf   <= n_ovf;
                r_pos   <= n_pos;
                r_fin   <= n_fin;
            end
            if (fire && emit)     r_res_valid <= 1'b1;
            else if (i_res_ready) r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_code  <= i_char_code;
            r_in_start <= i_string_start;
        end
        if (fire && emit) r_res <= n_res;
    end

    // accumulator only moves once a digit has been taken
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_fin && r_phase != PH_SOME) |-> (r_acc == 64'd0 && !r_ovf))
        else $error("accumulator nonzero before first digit");

    a_ovf_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_phase == PH_SOME))
        else $error("overflow without digits");

    a_no_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.no_digits) |->
            (r_res.value == 64'd0 && r_res.end_offset == 16'd0 && !r_res.range_error))
        else $error("no-digits result carries data");

    a_emit_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && emit) |=> r_fin)
        else $error("result given without finishing string");

endmodule

@@ sv/wide_string_to_int64_parser.sv @@
// ----------------------------------------------------------------------------
// wide_string_to_int64_parser
// Streaming wide-character string to signed/unsigned 64-bit integer parser.
// ----------------------------------------------------------------------------
// One UTF-16 code unit is taken per clock, back to back. Each unit passes an
// input register and then the parse logic (classification, a 64x6
// multiply-add with the limit compare) into the result register, which takes
// the result from the rejected unit that ends the number; the next string may follow at
// once. Throughput is one unit per cycle while the result side keeps up; a
// stalled result holds back input only when a second result is due.
// Configuration is to be written over APB while the block is idle; the block itself does not enforce this.
module wide_string_to_int64_parser import wsi_pkg::*; #(
    parameter int OFFSET_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wsi_char_if.sink    i_char,
    wsi_result_if.source o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg    cfg;
    t_result res;

    wsi_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    wsi_parse_core #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (i_char.valid),
        .o_in_ready     (i_char.ready),
        .i_char_code    (i_char.char_code),
        .i_string_start (i_char.string_start),
        .o_res_valid    (o_result.valid),
        .i_res_ready    (o_result.ready),
        .o_res          (res)
    );

    assign o_result.value       = res.value;
    assign o_result.end_offset  = res.end_offset;
    assign o_result.range_error = res.range_error;
    assign o_result.no_digits   = res.no_digits;

endmodule

@@ dv/wide_string_to_int64_parser_test.sv @@
// ----------------------------------------------------------------------------
// wide_string_to_int64_parser_test
// Self-checking bench for the streaming wide-string to 64-bit integer parser.
// Code units go in through a queue-fed driver and are run through a local
// parse model as they are accepted. The monitor compares each result with the
// oldest prediction. Phases step the APB registers across bases, both
// arithmetic modes and both prefix rules, with random stalls on both sides.
// ----------------------------------------------------------------------------
module wide_string_to_int64_parser_test import wsi_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        PS_SKIP_SPACE, PS_AFTER_SIGN, PS_LEAD_ZERO, PS_NO_DIGITS, PS_HAVE_DIGITS
    } t_parse_phase;

    typedef struct {
        logic [15:0] code;
        logic        start;
        logic        after_drain;
    } t_unit;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    wsi_char_if   chr();
    wsi_result_if res();

    wide_string_to_int64_parser dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (chr),
        .o_result (res),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // register shadow
    logic [5:0] cfg_base;
    logic       cfg_signed;
    logic       cfg_any_zero;

    // parse model state
    t_parse_phase pp_phase;
    logic         pp_negative;
    logic [5:0]   pp_base;
    logic [63:0]  pp_acc;
    logic         pp_overflow;
    logic [15:0]  pp_pos;
    logic         pp_done;

    t_unit       pending_units[$];
    t_result     expected_results[$];
    logic [6:0]  digit_buf[$];

    int unsigned char_issued;
    int unsigned char_accepted;
    int unsigned mismatches;
    int          tx_gap;
    int          rx_stall;
    int          tx_mode;
    int          rx_mode;
    bit          rx_hold;
    bit          next_start;
    bit          next_drain;
    bit          pause_next;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    // 0: never idle, 1: always random, 2: mostly back to back
    function automatic int draw_delay(input int mode);
        if (mode == 0) return 0;
        if (mode == 1) return $urandom_range(0, 17);
        return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 17) : 0;
    endfunction

    function automatic bit is_space(input logic [15:0] c);
        for (int i = 0; i < NUM_SPACES; i++)
            if (c == SPACE_CODES[i]) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [6:0] digit_value(input logic [15:0] c);
        logic [15:0] off;
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            off = c - DIGIT_BLOCKS[i];
            if (off <= 16'd9) return off[6:0];
        end
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return 7'(c - CH_LOWER_A + 16'd10);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return 7'(c - CH_UPPER_A + 16'd10);
        return DIGIT_NONE;
    endfunction

    function automatic bit is_prefix_zero(input logic [15:0] c);
        if (!cfg_any_zero) return c == CH_ZERO;
        for (int i = 0; i < NUM_BLOCKS; i++)
            if (c == DIGIT_BLOCKS[i]) return 1'b1;
        return 1'b0;
    endfunction

    // advance the parse model by one accepted code unit
    function automatic void parse_unit(input logic [15:0] c, input logic first_unit);
        logic [15:0] here;
        logic [6:0]  d;
        logic [63:0] lim;
        logic [63:0] cut;
        logic [63:0] cut_rem;
        logic        take_first;
        t_result     r;
        take_first = 1'b0;
        if (first_unit) begin
            pp_phase = PS_SKIP_SPACE;
            pp_negative = 1'b0;
            pp_base = '0;
            pp_acc = '0;
            pp_overflow = 1'b0;
            pp_pos = '0;
            pp_done = 1'b0;
        end
        if (pp_done) return;
        here = pp_pos;
        if (pp_pos != 16'hFFFF) pp_pos = pp_pos + 16'd1;

        case (pp_phase)
            PS_SKIP_SPACE: begin
                if (is_space(c)) return;
                if (c == CH_MINUS) begin
                    pp_negative = 1'b1;
                    pp_phase = PS_AFTER_SIGN;
                    return;
                end
                if (c == CH_PLUS) begin
                    pp_phase = PS_AFTER_SIGN;
                    return;
                end
                take_first = 1'b1;
            end
            PS_AFTER_SIGN: take_first = 1'b1;
            PS_LEAD_ZERO: begin
                if (c == CH_LOWER_X || c == CH_UPPER_X) begin
                    pp_base = BASE_HEX;
                    pp_phase = PS_NO_DIGITS;
                    return;
                end
                if (pp_base == BASE_AUTO) pp_base = BASE_OCT;
                pp_phase = PS_HAVE_DIGITS;  // the zero itself counts as a digit
            end
            default: ;
        endcase

        // base is latched on the first unit past the sign
        if (take_first) begin
            if ((cfg_base == BASE_AUTO || cfg_base == BASE_HEX) && is_prefix_zero(c)) begin
                pp_base = cfg_base;
                pp_phase = PS_LEAD_ZERO;
                return;
            end
            pp_base = (cfg_base == BASE_AUTO) ? BASE_DEC : cfg_base;
            pp_phase = PS_NO_DIGITS;
        end

        d = digit_value(c);
        if (pp_base != 6'd0 && d < pp_base) begin
            if (!pp_overflow) begin
                lim = cfg_signed ? (pp_negative ? S64_MIN : S64_MAX) : U64_MAX;
                cut = lim / pp_base;
                cut_rem = lim % pp_base;
                if (pp_acc > cut || (pp_acc == cut && d > cut_rem)) pp_overflow = 1'b1;
                else pp_acc = pp_acc * pp_base + d;
            end
            pp_phase = PS_HAVE_DIGITS;
            return;
        end

        pp_done = 1'b1;
        if (pp_phase != PS_HAVE_DIGITS) begin
            r = '{value: '0, end_offset: '0, range_error: 1'b0, no_digits: 1'b1};
        end else begin
            if (pp_overflow)
                r.value = cfg_signed ? (pp_negative ? S64_MIN : S64_MAX) : U64_MAX;
            else
                r.value = pp_negative ? (64'd0 - pp_acc) : pp_acc;
            r.range_error = pp_overflow;
            r.end_offset = here;
            r.no_digits = 1'b0;
        end
        expected_results.push_back(r);
    endfunction

    function automatic void note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // ---------------- stimulus building ----------------

    function automatic void begin_string();
        next_start = 1'b1;
        next_drain = pause_next || ($urandom_range(0, 39) == 0);
        pause_next = 1'b0;
    endfunction

    function automatic void add_unit(input logic [15:0] code);
        pending_units.push_back('{code: code, start: next_start, after_drain: next_drain});
        next_start = 1'b0;
        next_drain = 1'b0;
    endfunction

    function automatic void queue_text(input string s);
        begin_string();
        for (int i = 0; i < s.len(); i++) add_unit({8'h00, s[i]});
    endfunction

    function automatic logic [15:0] random_zero();
        return ($urandom_range(0, 1) == 0) ? CH_ZERO
                                           : DIGIT_BLOCKS[$urandom_range(0, NUM_BLOCKS - 1)];
    endfunction

    function automatic void add_digit(input logic [6:0] d);
        if (d < 7'd10)
            add_unit(random_zero() + 16'(d));
        else
            add_unit((($urandom_range(0, 1) == 0) ? CH_LOWER_A : CH_UPPER_A) + 16'(d) - 16'd10);
    endfunction

    function automatic void to_digits(input logic [63:0] v, input int unsigned b);
        logic [63:0] bw;
        bw = b;
        digit_buf.delete();
        do begin
            digit_buf.push_front(7'(v % bw));
            v = v / bw;
        end while (v != 0);
    endfunction

    // digit string plus one, may grow past 64 bits
    function automatic void add_one(input int unsigned b);
        int i;
        i = digit_buf.size() - 1;
        while (i >= 0 && digit_buf[i] == 7'(b - 1)) begin
            digit_buf[i] = 7'd0;
            i--;
        end
        if (i < 0) digit_buf.push_front(7'd1);
        else digit_buf[i] = digit_buf[i] + 7'd1;
    endfunction

    function automatic void queue_number();
        int unsigned radix;
        bit          neg;
        int          pfx;
        logic [63:0] lim;
        begin_string();
        repeat ($urandom_range(0, 2)) add_unit(SPACE_CODES[$urandom_range(0, NUM_SPACES - 1)]);
        neg = 1'b0;
        case ($urandom_range(0, 3))
            0: begin
                add_unit(CH_MINUS);
                neg = 1'b1;
            end
            1: add_unit(CH_PLUS);
            default: ;
        endcase
        // broken sequence: doubled sign or space after the sign
        if ($urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 2))
                0: add_unit(CH_PLUS);
                1: add_unit(CH_MINUS);
                default: add_unit(16'h0020);
            endcase
        end
        radix = cfg_base;
        pfx = $urandom_range(0, 3);
        if ((cfg_base == BASE_AUTO || cfg_base == BASE_HEX) && pfx == 0) begin
            add_unit(random_zero());
            add_unit(($urandom_range(0, 1) == 0) ? CH_LOWER_X : CH_UPPER_X);
            radix = 16;
        end else if (cfg_base == BASE_AUTO && pfx == 1) begin
            add_unit(random_zero());
            radix = 8;
        end else if (cfg_base == BASE_AUTO) begin
            radix = 10;
        end

        if (radix < 2 || radix > 36) begin
            digit_buf.delete();
            repeat ($urandom_range(0, 14))
                digit_buf.push_back(radix < 2 ? 7'd0 : 7'($urandom_range(0, 35)));
        end else begin
            lim = cfg_signed ? (neg ? S64_MIN : S64_MAX) : U64_MAX;
            case ($urandom_range(0, 9))
                0: to_digits(lim, radix);
                1: begin
                    to_digits(lim, radix);
                    add_one(radix);
                end
                2: to_digits(lim - 64'd1, radix);
                3: begin
                    to_digits({$urandom, $urandom}, radix);
                    repeat ($urandom_range(1, 3))
                        digit_buf.push_back(7'($urandom_range(0, radix - 1)));
                end
                4: digit_buf.delete();
                default: to_digits({$urandom, $urandom} >> $urandom_range(0, 63), radix);
            endcase
        end
        foreach (digit_buf[i]) add_digit(digit_buf[i]);

        // no terminator means the next string start abandons this one
        case ($urandom_range(0, 7))
            0, 1, 2: add_unit(16'h0000);
            3: add_unit(16'hFFFF);
            4: add_unit(16'h002E);
            5: add_unit(16'($urandom_range(0, 65535)));
            default: ;
        endcase
    endfunction

    function automatic void queue_noise();
        next_start = $urandom_range(0, 1);
        next_drain = 1'b0;
        repeat ($urandom_range(1, 5)) begin
            add_unit(16'($urandom_range(0, 65535)));
            next_start = ($urandom_range(0, 7) == 0);
        end
    endfunction

    function automatic void fill_random(input int budget);
        int counted;
        int size_was;
        counted = 0;
        while (counted < budget) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_noise();
            end else begin
                size_was = pending_units.size();
                queue_number();
                counted += pending_units.size() - size_was;
            end
        end
    endfunction

    // ---------------- bus tasks ----------------

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_NUMBER_BASE:    cfg_base = val[5:0];
            REG_SIGNED_MODE:    cfg_signed = val[0];
            REG_ANY_BLOCK_ZERO: cfg_any_zero = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // results are registered after the closing unit; margin for units with none
    task automatic wait_block_idle();
        while (pending_units.size() != 0 || char_accepted != char_issued ||
               expected_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(input int unsigned base, input bit sgn, input bit any_zero,
                             input int txm, input int rxm, input int budget);
        wait_block_idle();
        write_reg(REG_NUMBER_BASE, base);
        write_reg(REG_SIGNED_MODE, sgn);
        write_reg(REG_ANY_BLOCK_ZERO, any_zero);
        tx_mode = txm;
        rx_mode = rxm;
        fill_random(budget);
    endtask

    // ---------------- driver / receiver / monitor ----------------

    always @(negedge i_clk) begin
        t_unit u;
        if (!i_rst_n) begin
            chr.valid <= 1'b0;
        end else if (!chr.valid || char_accepted == char_issued) begin
            if (tx_gap > 0) begin
                tx_gap--;
                chr.valid <= 1'b0;
            end else if (pending_units.size() != 0 &&
                         !(pending_units[0].after_drain && expected_results.size() != 0)) begin
                u = pending_units.pop_front();
                chr.char_code <= u.code;
                chr.string_start <= u.start;
                chr.valid <= 1'b1;
                char_issued++;
                tx_gap = draw_delay(tx_mode);
            end else begin
                chr.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || rx_hold) begin
            res.ready <= 1'b0;
        end else if (rx_stall > 0) begin
            res.ready <= 1'b0;
            rx_stall--;
        end else begin
            res.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (chr.valid && chr.ready) begin
                parse_unit(chr.char_code, chr.string_start);
                char_accepted++;
            end
            if (res.valid && res.ready) begin
                if (expected_results.size() == 0) begin
                    note_failure($sformatf("unexpected result value=%h off=%0d re=%b nd=%b",
                        res.value, res.end_offset, res.range_error, res.no_digits));
                end else begin
                    want = expected_results.pop_front();
                    if (want.value !== res.value || want.end_offset !== res.end_offset ||
                        want.range_error !== res.range_error || want.no_digits !== res.no_digits)
                        note_failure($sformatf(
                            {"mismatch exp value=%h off=%0d re=%b nd=%b,",
                             " got value=%h off=%0d re=%b nd=%b"},
                            want.value, want.end_offset, want.range_error, want.no_digits,
                            res.value, res.end_offset, res.range_error, res.no_digits));
                end
                rx_stall = draw_delay(rx_mode);
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        chr.valid = 1'b0;
        chr.char_code = '0;
        chr.string_start = 1'b0;
        res.ready = 1'b0;
        cfg_base = BASE_AUTO;
        cfg_signed = 1'b1;
        cfg_any_zero = 1'b0;
        pp_phase = PS_SKIP_SPACE;
        pp_negative = 1'b0;
        pp_base = '0;
        pp_acc = '0;
        pp_overflow = 1'b0;
        pp_pos = '0;
        pp_done = 1'b1;
        char_issued = 0;
        char_accepted = 0;
        mismatches = 0;
        tx_gap = 0;
        rx_stall = 0;
        tx_mode = 2;
        rx_mode = 2;
        rx_hold = 1'b0;
        next_start = 1'b0;
        next_drain = 1'b0;
        pause_next = 1'b0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset register values
        pending_units.push_back('{code: 16'h0031, start: 1'b0, after_drain: 1'b0});
        pending_units.push_back('{code: 16'hFFFF, start: 1'b0, after_drain: 1'b0});
        queue_text("\t-0xg");            // hex prefix with no digit after it
        queue_text("07");                 // auto octal
        add_unit(16'h0000);
        queue_text("5");                  // abandoned by the next start
        queue_text("9");
        add_unit(16'hFFFF);
        begin_string();                   // fullwidth and arabic-indic digits
        add_unit(16'hFF11);
        add_unit(16'h0669);
        add_unit(16'h0000);
        queue_text("+z");

        // long run of leading whitespace
        wait_block_idle();
        tx_mode = 0;
        rx_mode = 0;
        begin_string();
        repeat (40) add_unit(16'h0020);
        add_unit(16'h0037);
        add_unit(16'h0000);

        wait_block_idle();
        tx_mode = 2;
        rx_mode = 2;
        fill_random(150);

        run_phase(10, 1'b0, 1'b0, 1, 1, 150);
        run_phase(16, 1'b1, 1'b1, 0, 0, 150);
        run_phase(0,  1'b0, 1'b1, 1, 2, 150);
        run_phase(2,  1'b1, 1'b0, 2, 1, 100);
        run_phase(36, 1'b0, 1'b1, 2, 0, 150);
        run_phase(1,  1'b1, 1'b0, 1, 1, 80);
        run_phase(63, 1'b0, 1'b1, 0, 1, 120);

        // result side held off while requests keep coming, then a drained pause
        wait_block_idle();
        write_reg(REG_NUMBER_BASE, 10);
        write_reg(REG_SIGNED_MODE, 1);
        write_reg(REG_ANY_BLOCK_ZERO, 0);
        tx_mode = 0;
        rx_mode = 0;
        fork
            begin
                rx_hold = 1'b1;
                repeat (400) @(posedge i_clk);
                rx_hold = 1'b0;
            end
        join_none
        fill_random(120);
        pause_next = 1'b1;
        fill_random(120);

        run_phase(8, 1'b0, 1'b0, 1, 1, 120);
        repeat (2)
            run_phase($urandom_range(0, 63), $urandom_range(0, 1), $urandom_range(0, 1),
                      $urandom_range(0, 2), $urandom_range(0, 2), 120);

        wait_block_idle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
